// ===== rtl/tgd_pkg.sv =====
// Package for the tilt gesture detector: field widths, register indexes,
// reset values, item kinds, commands and the structs passed between modules.
// No dependencies.
`default_nettype none

package tgd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int THR_W      = 15;
    localparam int HOLD_W     = 8;
    localparam int CNT_W      = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int QDEPTH     = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd2;

    localparam logic              RST_ENABLE    = 1'b1;
    localparam logic [THR_W-1:0]  RST_THRESHOLD = 15'd4000;
    localparam logic [HOLD_W-1:0] RST_HOLDOFF   = 8'd5;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_CAL_SAMPLE = 2'd0,
        KIND_IGNORE     = 2'd1,
        KIND_TICK       = 2'd2,
        KIND_SAMPLE     = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic                        cal_last;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_task;

    typedef struct packed {
        t_cmd                        command;
        logic                        ready_res;
        logic                        calibrating;
        logic signed [SAMPLE_W-1:0]  corrected;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== rtl/tgd_front.sv =====
// Front end: accepts input transactions and tags each with its kind.
// Counts calibration samples itself. Depends on tgd_pkg.
`default_nettype none

module tgd_front #(
    parameter int CAL_SAMPLES = 100
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_operation,
    input  wire logic [tgd_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output tgd_pkg::t_task                     o_task
);
    import tgd_pkg::*;

    localparam logic [CNT_W-1:0] CAL_N    = CNT_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

    logic [CNT_W-1:0] r_cal_cnt;
    logic [CNT_W-1:0] n_cal_cnt;
    logic             w_calib;
    logic             w_accept;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    assign w_calib    = r_cal_cnt < CAL_N;
    assign o_push     = w_accept;

    always_comb begin
        o_task.sample   = $signed(i_sample);
        o_task.cal_last = 1'b0;
        n_cal_cnt       = r_cal_cnt;
        if (w_calib) begin
            if (t_op'(i_operation) == OP_SAMPLE) begin
                o_task.kind     = KIND_CAL_SAMPLE;
                o_task.cal_last = (r_cal_cnt == CAL_LAST);
                if (w_accept) begin
                    n_cal_cnt = r_cal_cnt + 1'b1;
                end
            end else begin
                o_task.kind = KIND_IGNORE;
            end
        end else if (t_op'(i_operation) == OP_SAMPLE) begin
            o_task.kind = KIND_SAMPLE;
        end else begin
            o_task.kind = KIND_TICK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_cnt <= '0;
        end else begin
            r_cal_cnt <= n_cal_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgd_fifo.sv =====
// Short queue of tagged items between the front and back ends.
// Depends on tgd_pkg.
`default_nettype none

module tgd_fifo (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  tgd_pkg::t_task i_data,
    output logic         o_full,
    output logic         o_valid,
    output tgd_pkg::t_task o_data,
    input  wire logic    i_pop
);
    import tgd_pkg::*;

    localparam int AW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_task           r_mem [QDEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgd_div.sv =====
// Divider by a fixed divisor through a constant reciprocal: the dividend is
// registered, then multiplied and shifted in the next cycle. Depends on tgd_pkg.
`default_nettype none

module tgd_div #(
    parameter int DIVISOR = 100
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tgd_pkg::SUM_W-1:0]  i_dividend,
    output tgd_pkg::t_div_stat              o_stat,
    output logic [tgd_pkg::SUM_W-1:0]       o_quotient
);
    import tgd_pkg::*;

    // ceil(2^(SUM_W+L) / DIVISOR) yields the exact floor quotient for every
    // unsigned SUM_W-bit dividend
    localparam int              L       = $clog2(DIVISOR);
    localparam int              SH      = SUM_W + L;
    localparam int              PW      = 2 * SUM_W + 1;
    localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1)
                                          / 64'(DIVISOR);
    localparam logic [SUM_W:0]  RECIP   = (SUM_W + 1)'(RECIP_L);

    logic                r_busy;
    logic                r_done;
    logic [SUM_W-1:0]    r_arg;
    logic [SUM_W-1:0]    r_quo;
    logic [PW-1:0]       w_prod;
    logic [PW-1:0]       w_quo_sh;

    assign w_prod     = {{(SUM_W + 1){1'b0}}, r_arg} * {{SUM_W{1'b0}}, RECIP};
    assign w_quo_sh   = w_prod >> SH;
    assign o_stat     = '{busy: r_busy, done: r_done};
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_arg <= i_dividend;
        end
        if (r_busy) begin
            r_quo <= w_quo_sh[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgd_back.sv =====
// Back end: carries out tagged items against the detector state and the
// configuration registers, and holds the result register. Depends on tgd_pkg.
`default_nettype none

module tgd_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tgd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_task_valid,
    input  tgd_pkg::t_task                      i_task,
    output logic                                o_pop,
    output logic                                o_div_start,
    output logic [tgd_pkg::SUM_W-1:0]           o_div_dividend,
    input  tgd_pkg::t_div_stat                  i_div_stat,
    input  wire logic [tgd_pkg::SUM_W-1:0]      i_div_quotient,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output tgd_pkg::t_result                    o_result
);
    import tgd_pkg::*;

    logic                        r_enable;
    logic [THR_W-1:0]            r_threshold;
    logic [HOLD_W-1:0]           r_holdoff;
    logic signed [SUM_W-1:0]     r_cal_sum;
    logic [SAMPLE_W-1:0]         r_offset;
    logic [HOLD_W-1:0]           r_skip;
    logic                        r_ready;
    logic                        r_div_pend;
    logic                        r_out_valid;
    t_result                     r_out;

    logic signed [SUM_W-1:0]     n_cal_sum;
    logic [SAMPLE_W-1:0]         n_offset;
    logic [HOLD_W-1:0]           n_skip;
    logic                        n_ready;
    logic                        n_div_pend;
    t_result                     n_out;

    logic                        w_block;
    logic [SAMPLE_W-1:0]         w_corr;
    logic signed [SAMPLE_W:0]    w_x;
    logic signed [SAMPLE_W:0]    w_thr;
    logic signed [SAMPLE_W:0]    w_x_plus_thr;

    // hold items back while the calibration mean is being formed
    assign w_block     = r_div_pend || i_div_stat.busy || i_div_stat.done;
    assign o_pop       = i_task_valid && !w_block && (!r_out_valid || i_out_ready);
    assign o_div_start = r_div_pend;
    assign o_div_dividend = r_cal_sum[SUM_W-1] ? SUM_W'(-r_cal_sum) : SUM_W'(r_cal_sum);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign w_corr       = i_task.sample + r_offset;
    assign w_x          = {w_corr[SAMPLE_W-1], w_corr};
    assign w_thr        = {2'b00, r_threshold};
    assign w_x_plus_thr = w_x + w_thr;

    always_comb begin
        n_cal_sum  = r_cal_sum;
        n_offset   = r_offset;
        n_skip     = r_skip;
        n_ready    = r_ready;
        n_div_pend = 1'b0;
        n_out      = '{command: CMD_NONE, ready_res: 1'b0, calibrating: 1'b0,
                       corrected: '0};

        if (i_div_stat.done) begin
            // offset is minus the truncated mean
            n_offset = r_cal_sum[SUM_W-1] ? i_div_quotient[SAMPLE_W-1:0]
                                          : SAMPLE_W'(-i_div_quotient[SAMPLE_W-1:0]);
        end

        if (o_pop) begin
            case (i_task.kind)
                KIND_CAL_SAMPLE: begin
                    n_cal_sum = r_cal_sum
                              + {{(SUM_W - SAMPLE_W){i_task.sample[SAMPLE_W-1]}},
                                 i_task.sample};
                    n_div_pend        = i_task.cal_last;
                    n_out.calibrating = !i_task.cal_last;
                end
                KIND_IGNORE: begin
                    n_out.calibrating = 1'b1;
                end
                KIND_TICK: begin
                    if (r_enable) begin
                        if (r_skip == '0) begin
                            n_ready = 1'b1;
                        end else begin
                            n_skip = r_skip - 1'b1;
                        end
                    end
                end
                KIND_SAMPLE: begin
                    if (r_ready) begin
                        n_ready         = 1'b0;
                        n_out.corrected = $signed(w_corr);
                        if (w_x > w_thr) begin
                            n_out.command = CMD_LEFT;
                            n_skip        = r_skip + r_holdoff;
                        end else if (w_x_plus_thr < 0) begin
                            n_out.command = CMD_RIGHT;
                            n_skip        = r_skip + r_holdoff;
                        end
                    end
                end
                default: begin
                    n_ready = r_ready;
                end
            endcase
            if (!r_enable) begin
                n_ready = 1'b0;
            end
            n_out.ready_res = n_ready;
        end

        // dropping enable clears ready at once
        if (i_cfg_we && (i_cfg_index == REG_ENABLE) && !i_cfg_data[0]) begin
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= RST_ENABLE;
            r_threshold <= RST_THRESHOLD;
            r_holdoff   <= RST_HOLDOFF;
            r_cal_sum   <= '0;
            r_offset    <= '0;
            r_skip      <= '0;
            r_ready     <= 1'b0;
            r_div_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cal_sum  <= n_cal_sum;
            r_offset   <= n_offset;
            r_skip     <= n_skip;
            r_ready    <= n_ready;
            r_div_pend <= n_div_pend;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ENABLE:    r_enable    <= i_cfg_data[0];
                    REG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    REG_HOLDOFF:   r_holdoff   <= i_cfg_data[HOLD_W-1:0];
                    default:       r_enable    <= r_enable;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tilt_gesture_detector.sv =====
// Top level of the tilt gesture detector: front end, item queue, back end
// and calibration divider. Depends on tgd_pkg and the tgd_* modules.
//
//  Channel   Direction  Handshake                   Payload
//  in        to block   i_in_valid / o_in_ready     i_operation, i_sample
//  out       from block o_out_valid / i_out_ready   o_command, o_ready_res,
//                                                   o_calibrating, o_corrected
//  cfg       to block   i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// One item per cycle sustained while neither the output nor the divider stalls;
// each item passes the queue and then the output register, loaded as it leaves
// the queue. After the last calibration sample the back end holds the queue
// (start, multiply by the constant reciprocal, load the offset) while the mean is
// formed; the two-entry queue takes up to two transactions meanwhile.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output register stalls the back end; a full queue drops o_in_ready.
`default_nettype none

module tilt_gesture_detector #(
    parameter int CAL_SAMPLES = 100
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tgd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_operation,
    input  wire logic [tgd_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [tgd_pkg::CMD_W-1:0]           o_command,
    output logic                                o_ready_res,
    output logic                                o_calibrating,
    output logic [tgd_pkg::SAMPLE_W-1:0]        o_corrected
);
    import tgd_pkg::*;

    logic              w_push;
    t_task             w_push_task;
    logic              w_q_full;
    logic              w_q_valid;
    t_task             w_q_task;
    logic              w_pop;
    logic              w_div_start;
    logic [SUM_W-1:0]  w_div_dividend;
    t_div_stat         w_div_stat;
    logic [SUM_W-1:0]  w_div_quotient;
    t_result           w_result;

    // classify each accepted transaction and push it into the queue
    tgd_front #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_sample    (i_sample),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_task      (w_push_task)
    );

    // decouple the two ends
    tgd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_task),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_task),
        .i_pop   (w_pop)
    );

    // form the calibration mean by reciprocal multiplication
    tgd_div #(
        .DIVISOR (CAL_SAMPLES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .o_stat     (w_div_stat),
        .o_quotient (w_div_quotient)
    );

    // execute items and hold the result register
    tgd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_task_valid   (w_q_valid),
        .i_task         (w_q_task),
        .o_pop          (w_pop),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .i_div_stat     (w_div_stat),
        .i_div_quotient (w_div_quotient),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (w_result)
    );

    assign o_command     = w_result.command;
    assign o_ready_res   = w_result.ready_res;
    assign o_calibrating = w_result.calibrating;
    assign o_corrected   = w_result.corrected;

`ifndef SYNTHESIS
    // no result of a calibrating item carries a command or a corrected value
    a_calib_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_calibrating) |-> (o_command == CMD_NONE && o_corrected == '0))
        else $error("command or corrected value during calibration");

    // a command comes only from a sample taken while ready, which clears ready
    a_cmd_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_command != CMD_NONE) |-> !o_ready_res)
        else $error("ready still set after a command");

    // no item leaves the queue while the divider is still running
    a_hold_during_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> !w_pop)
        else $error("item executed while calibration mean pending");

    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_tilt_gesture_detector.sv =====
// Testbench for tilt_gesture_detector: directed and randomised transactions on the
// input channel, each result checked field by field against a behavioural predictor.
// Depends on tgd_pkg and rtl/tilt_gesture_detector.sv.
`default_nettype none

module tb_tilt_gesture_detector;
    import tgd_pkg::*;

    localparam int CAL_SAMPLES = 100;
    localparam int MAX_GAP     = 14;
    localparam int DRAIN_TAIL  = 40;   // covers the divider pause and the output register

    // DUT inputs start at known values
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_ENABLE;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_operation = OP_TICK;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [CMD_W-1:0]      o_command;
    logic                  o_ready_res;
    logic                  o_calibrating;
    logic [SAMPLE_W-1:0]   o_corrected;

    // predictor copy of the registers and the block state
    logic                    cfg_enable    = RST_ENABLE;
    logic [THR_W-1:0]        cfg_threshold = RST_THRESHOLD;
    logic [HOLD_W-1:0]       cfg_holdoff   = RST_HOLDOFF;
    logic signed [SUM_W-1:0] acc_sum       = '0;
    logic [CNT_W-1:0]        acc_count     = '0;
    logic [SAMPLE_W-1:0]     zero_offset   = '0;
    logic [HOLD_W-1:0]       skip_left     = '0;
    logic                    armed         = 1'b0;

    t_result     pending_gestures[$];
    int unsigned mismatches = 0;
    bit          idle_on    = 1'b1;   // clear for stretches with no gaps on either side
    int unsigned out_hold   = 0;      // long receiver hold-off, counted down by the receiver
    int unsigned out_stall  = 0;

    tilt_gesture_detector #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_command     (o_command),
        .o_ready_res   (o_ready_res),
        .o_calibrating (o_calibrating),
        .o_corrected   (o_corrected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tilt_gesture_detector: mismatch");
        $finish;
    end

    function automatic int unsigned draw_gap();
        return idle_on ? $urandom_range(MAX_GAP, 0) : 0;
    endfunction

    // Advance the predictor by one accepted transaction and return the result it causes.
    function automatic t_result predict_gesture(input t_op op, input logic [SAMPLE_W-1:0] raw);
        t_result res;
        int      quotient;
        int      level;
        int      limit;
        res = '0;
        res.command = CMD_NONE;
        if (acc_count < CAL_SAMPLES) begin
            // ticks are dropped until calibration completes
            if (op == OP_SAMPLE) begin
                acc_sum   = acc_sum + $signed(raw);
                acc_count = acc_count + 1'b1;
                if (acc_count >= CAL_SAMPLES) begin
                    // mean truncated toward zero, then negated into the offset
                    quotient    = acc_sum;
                    quotient    = quotient / CAL_SAMPLES;
                    zero_offset = SAMPLE_W'(-quotient);
                end
            end
        end else if (op == OP_TICK) begin
            if (cfg_enable) begin
                if (skip_left == '0)
                    armed = 1'b1;
                else
                    skip_left = skip_left - 1'b1;
            end
        end else if (armed) begin
            armed         = 1'b0;
            res.corrected = raw + zero_offset;
            level         = $signed(res.corrected);
            limit         = cfg_threshold;
            if (level > limit) begin
                res.command = CMD_LEFT;
                skip_left   = skip_left + cfg_holdoff;
            end else if (level < -limit) begin
                res.command = CMD_RIGHT;
                skip_left   = skip_left + cfg_holdoff;
            end
        end
        if (!cfg_enable)
            armed = 1'b0;
        res.ready_res   = armed;
        res.calibrating = (acc_count < CAL_SAMPLES);
        return res;
    endfunction

    // Raw sample that the current offset turns into the given corrected level.
    function automatic logic [SAMPLE_W-1:0] raw_giving(input int level);
        return SAMPLE_W'(level) - zero_offset;
    endfunction

    // Offer one transaction after a random gap and hold it until accepted. The caller
    // must send again or call wait_for_results in the step this task returns in, so that
    // valid is never left high after acceptance.
    task automatic send_item(input t_op op, input logic [SAMPLE_W-1:0] raw);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_sample    <= raw;
        do @(posedge i_clk); while (!o_in_ready);
        pending_gestures.push_back(predict_gesture(op, raw));
    endtask

    // Drop valid and hold until every predicted result has been checked.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_gestures.size() != 0);
    endtask

    // Write one register; only called with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_ENABLE: begin
                cfg_enable = data[0];
                if (!data[0])
                    armed = 1'b0;
            end
            REG_THRESHOLD: cfg_threshold = data[THR_W-1:0];
            REG_HOLDOFF:   cfg_holdoff   = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // Send ticks until the detector is ready for a sample; enable must be set.
    task automatic arm_detector();
        while (!armed)
            send_item(OP_TICK, SAMPLE_W'($urandom));
    endtask

    // Calibration: samples clustered round a random mean, both raw extremes among them,
    // with ticks mixed in that must be dropped. Follow on with no drain so that items
    // queue up behind the divider.
    task automatic test_calibration();
        int base;
        int level;
        int n;
        base = int'($urandom_range(40000, 0)) - 20000;
        n    = 0;
        while (n < CAL_SAMPLES) begin
            if ($urandom_range(3, 0) == 0) begin
                send_item(OP_TICK, SAMPLE_W'($urandom));
            end else begin
                if (n == 0)
                    level = 32767;
                else if (n == 1)
                    level = -32768;
                else
                    level = base + int'($urandom_range(4000, 0)) - 2000;
                send_item(OP_SAMPLE, SAMPLE_W'(level));
                n++;
            end
        end
        send_item(OP_TICK, SAMPLE_W'($urandom));
        send_item(OP_SAMPLE, SAMPLE_W'($urandom));
    endtask

    // Threshold edges: exactly on it gives nothing, one past it gives a command,
    // then threshold zero and threshold at its maximum.
    task automatic test_boundaries();
        int thr;
        wait_for_results();
        write_reg(REG_HOLDOFF, CFG_DATA_W'(1));
        send_item(OP_SAMPLE, SAMPLE_W'(16'h7FFF));   // not ready yet: dropped
        thr = cfg_threshold;
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(thr));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(thr + 1));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(-thr));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(-thr - 1));
        wait_for_results();
        write_reg(REG_THRESHOLD, '0);
        write_reg(REG_HOLDOFF, '0);
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(0));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(1));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(-1));
        wait_for_results();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(15'h7FFF));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(32767));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(-32768));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(-32767));
    endtask

    // Disable: ticks must not count down the holdoff, samples are dropped, and a
    // disable write clears ready at once.
    task automatic test_disable();
        wait_for_results();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(100));
        write_reg(REG_HOLDOFF, CFG_DATA_W'(3));
        arm_detector();
        send_item(OP_SAMPLE, raw_giving(1000));
        wait_for_results();
        write_reg(REG_ENABLE, CFG_DATA_W'($urandom << 1));
        send_item(OP_TICK, SAMPLE_W'($urandom));
        send_item(OP_TICK, SAMPLE_W'($urandom));
        send_item(OP_SAMPLE, SAMPLE_W'($urandom));
        wait_for_results();
        write_reg(REG_ENABLE, CFG_DATA_W'($urandom << 1) | CFG_DATA_W'(1));
        arm_detector();
        wait_for_results();
        write_reg(REG_ENABLE, '0);
        send_item(OP_SAMPLE, SAMPLE_W'($urandom));
        wait_for_results();
        write_reg(REG_ENABLE, CFG_DATA_W'(1));
    endtask

    // Random phases, each with its own settings. Most traffic is tick runs ending in a
    // sample, with samples often placed right at the threshold; samples sent while not
    // ready act as noise and do not count toward the phase length.
    task automatic test_random();
        int unsigned useful;
        int unsigned sent;
        int unsigned thr;
        int unsigned hold;
        int          level;
        t_op         op;
        logic [SAMPLE_W-1:0] raw;
        for (int phase = 0; phase < 9; phase++) begin
            wait_for_results();
            case (phase)
                0: begin
                    thr  = 32767;
                    hold = 255;
                end
                1: begin
                    thr  = 0;
                    hold = 0;
                end
                default: begin
                    case ($urandom_range(5, 0))
                        0:       thr = 0;
                        1:       thr = 32767;
                        default: thr = $urandom_range(12000, 0);
                    endcase
                    hold = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
            endcase
            write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
            // upper data bits above the holdoff width must be ignored
            write_reg(REG_HOLDOFF, CFG_DATA_W'($urandom << HOLD_W) | CFG_DATA_W'(hold));
            idle_on = ($urandom_range(3, 0) != 0);
            if (phase == 4) begin
                write_reg(REG_ENABLE, '0);
                repeat (20) begin
                    op = t_op'($urandom_range(1, 0));
                    send_item(op, SAMPLE_W'($urandom));
                end
                wait_for_results();
                write_reg(REG_ENABLE, CFG_DATA_W'(1));
            end
            useful = 0;
            sent   = 0;
            while (useful < 70) begin
                // back-pressure: stall the receiver long enough to fill the block
                if (phase == 2 && sent == 20) begin
                    idle_on  = 1'b0;
                    out_hold = 120;
                end
                if (phase == 2 && sent == 70)
                    idle_on = 1'b1;
                // pause the sender until every result is home
                if (phase == 6 && sent == 50)
                    wait_for_results();
                op = ($urandom_range(armed ? 2 : 5, 0) == 0) ? OP_SAMPLE : OP_TICK;
                if (op == OP_SAMPLE && $urandom_range(1, 0) == 1) begin
                    level = int'(cfg_threshold) + int'($urandom_range(4, 0)) - 2;
                    if ($urandom_range(1, 0) == 1)
                        level = -level;
                    raw = raw_giving(level);
                end else begin
                    raw = SAMPLE_W'($urandom);
                end
                if ((op == OP_TICK && cfg_enable) || (op == OP_SAMPLE && armed))
                    useful++;
                sent++;
                send_item(op, raw);
            end
        end
    endtask

    // Receiver: draw a stall after each transaction, honour the long hold-off first.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                out_stall = draw_gap();
            if (out_hold != 0) begin
                out_hold--;
                i_out_ready <= 1'b0;
            end else if (out_stall != 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_gestures.size() == 0) begin
                $display("%0t: result with none expected: command %0d corrected %0d",
                         $time, o_command, $signed(o_corrected));
                mismatches++;
            end else begin
                want = pending_gestures.pop_front();
                if (o_command !== want.command) begin
                    $display("%0t: command expected %0d, got %0d",
                             $time, want.command, o_command);
                    mismatches++;
                end
                if (o_ready_res !== want.ready_res) begin
                    $display("%0t: ready_res expected %0d, got %0d",
                             $time, want.ready_res, o_ready_res);
                    mismatches++;
                end
                if (o_calibrating !== want.calibrating) begin
                    $display("%0t: calibrating expected %0d, got %0d",
                             $time, want.calibrating, o_calibrating);
                    mismatches++;
                end
                if (o_corrected !== want.corrected) begin
                    $display("%0t: corrected expected %0d, got %0d",
                             $time, $signed(want.corrected), $signed(o_corrected));
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_calibration();
        test_boundaries();
        test_disable();
        test_random();
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0 && pending_gestures.size() == 0) begin
            $display("tilt_gesture_detector: match");
        end else begin
            $display("tilt_gesture_detector: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
